// ===== rtl/sapq_pkg.sv =====
// Shared types and constants for the sorted array priority queue.
package sapq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_EMPTY    = 2'd2;
    localparam logic [1:0] STS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        data_t      value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        data_t            entry_value;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // controller to datapath
    typedef struct packed {
        op_t        op;
        logic       ptr_clear;
        logic       ptr_step;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_entry;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic rd_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/sapq_dp.sv =====
// Datapath: entry cell chain, count, read pointer and output register.
module sapq_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  sapq_pkg::data_t    value,
    input  sapq_pkg::cmd_t     cmd,
    output sapq_pkg::sts_t     sts,
    output logic               out_valid,
    input  logic               out_stall,
    output sapq_pkg::out_item_t out_data
);

    sapq_pkg::data_t              entry_reg  [sapq_pkg::DEPTH];
    sapq_pkg::data_t              entry_next [sapq_pkg::DEPTH];
    logic [sapq_pkg::DEPTH-1:0]   live;
    logic [sapq_pkg::DEPTH-1:0]   ge;
    logic [sapq_pkg::DEPTH-1:0]   eq;

    logic [sapq_pkg::CNT_W-1:0]   count_reg;
    logic [sapq_pkg::CNT_W-1:0]   count_next;
    logic [sapq_pkg::IDX_W-1:0]   rd_ptr_reg;
    logic [sapq_pkg::IDX_W-1:0]   rd_ptr_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    sapq_pkg::out_item_t          out_data_reg;
    sapq_pkg::out_item_t          out_data_next;

    // per-cell compare against the request value
    always_comb
    begin
        for (int i = 0; i < sapq_pkg::DEPTH; i++)
        begin
            live[i] = sapq_pkg::CNT_W'(i) < count_reg;
            ge[i]   = value >= entry_reg[i];
            eq[i]   = live[i] && (value == entry_reg[i]);
        end
    end

    // Entries are descending, so ge marks the tail from the insert point,
    // and on a delete it marks the matched entry and everything after it.
    genvar g;
    generate
        for (g = 0; g < sapq_pkg::DEPTH; g++)
        begin : g_cell
            logic take_prev;
            if (g == 0)
            begin : g_first
                assign take_prev = 1'b0;
            end
            else
            begin : g_rest
                assign take_prev = !live[g-1] || ge[g-1];
            end

            always_comb
            begin
                entry_next[g] = entry_reg[g];
                case (cmd.op)
                    sapq_pkg::OP_INSERT:
                    begin
                        if (!live[g] || ge[g])
                        begin
                            if (g == 0)
                            begin
                                entry_next[g] = value;
                            end
                            else
                            begin
                                entry_next[g] = take_prev ? entry_reg[(g == 0) ? 0 : g-1]
                                                          : value;
                            end
                        end
                    end
                    sapq_pkg::OP_DELETE:
                    begin
                        if (live[g] && ge[g] && (g < sapq_pkg::DEPTH - 1))
                        begin
                            entry_next[g] =
                                entry_reg[(g < sapq_pkg::DEPTH - 1) ? g+1 : g];
                        end
                    end
                    default:
                    begin
                        entry_next[g] = entry_reg[g];
                    end
                endcase
            end

            always_ff @(posedge clk)
            begin
                entry_reg[g] <= entry_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        case (cmd.op)
            sapq_pkg::OP_INSERT: count_next = count_reg + sapq_pkg::CNT_W'(1);
            sapq_pkg::OP_DELETE: count_next = count_reg - sapq_pkg::CNT_W'(1);
            default:             count_next = count_reg;
        endcase

        rd_ptr_next = rd_ptr_reg;
        if (cmd.ptr_clear)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.ptr_step)
        begin
            rd_ptr_next = rd_ptr_reg + sapq_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        sts.full     = count_reg == sapq_pkg::CNT_W'(sapq_pkg::DEPTH);
        sts.empty    = count_reg == '0;
        sts.found    = |eq;
        sts.rd_last  = (sapq_pkg::CNT_W'(rd_ptr_reg) + sapq_pkg::CNT_W'(1)) == count_reg;
        sts.out_busy = out_valid_reg && out_stall;
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = cmd.out_status;
            out_data_next.entry_count = count_next;
            if (cmd.out_entry)
            begin
                out_data_next.entry_value = entry_reg[rd_ptr_reg];
                out_data_next.last        = sts.rd_last;
            end
            else
            begin
                out_data_next.entry_value = '0;
                out_data_next.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/sapq_ctrl.sv =====
// Controller: request decode and read-out sequencing.
module sapq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     req_type,
    output logic           in_stall,
    input  sapq_pkg::sts_t sts,
    output sapq_pkg::cmd_t cmd
);

    sapq_pkg::state_t state_reg;
    sapq_pkg::state_t state_next;
    logic             take;

    assign take = in_valid && !sts.out_busy && (state_reg == sapq_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sapq_pkg::ST_IDLE:
            begin
                if (take && (req_type == sapq_pkg::REQ_READ) && !sts.empty)
                begin
                    state_next = sapq_pkg::ST_READ;
                end
            end
            sapq_pkg::ST_READ:
            begin
                if (!sts.out_busy && sts.rd_last)
                begin
                    state_next = sapq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sapq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = sapq_pkg::OP_NONE;
        cmd.out_status = sapq_pkg::STS_OK;
        in_stall       = (state_reg != sapq_pkg::ST_IDLE) || sts.out_busy;
        case (state_reg)
            sapq_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (req_type)
                        sapq_pkg::REQ_INSERT:
                        begin
                            cmd.out_load = 1'b1;
                            if (sts.full)
                            begin
                                cmd.out_status = sapq_pkg::STS_FULL;
                            end
                            else
                            begin
                                cmd.op = sapq_pkg::OP_INSERT;
                            end
                        end
                        sapq_pkg::REQ_DELETE:
                        begin
                            cmd.out_load = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.out_status = sapq_pkg::STS_EMPTY;
                            end
                            else if (!sts.found)
                            begin
                                cmd.out_status = sapq_pkg::STS_NOTFOUND;
                            end
                            else
                            begin
                                cmd.op = sapq_pkg::OP_DELETE;
                            end
                        end
                        sapq_pkg::REQ_READ:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = sapq_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                cmd.ptr_clear = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.op = sapq_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            sapq_pkg::ST_READ:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_entry = 1'b1;
                    cmd.ptr_step  = 1'b1;
                end
            end
            default:
            begin
                cmd.op = sapq_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sapq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sorted_array_priority_queue_core.sv =====
// Top level of the sorted array priority queue.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_data  (req_type, value)
//   out      output     out_valid / out_stall out_data (status, entry_value,
//                                                       entry_count, last)
//
// Insert and delete finish in the cycle of the transfer: every cell compares and
// shifts at once, so one such request can be taken each cycle while not stalled.
// A read first clears the pointer, then gives one entry per cycle, while not
// stalled, from the single read port on the cell chain.
// Reset clears the count, pointer and output valid; entry contents are not reset.
// A stalled output holds its result and stalls the input in turn.
module sorted_array_priority_queue_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sapq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sapq_pkg::out_item_t out_data
);

    sapq_pkg::cmd_t cmd;
    sapq_pkg::sts_t sts;

    sapq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sapq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (in_data.value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== bench/sorted_array_priority_queue_core_tb.sv =====
// Self-checking testbench for the sorted array priority queue core.
module sorted_array_priority_queue_core_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam sapq_pkg::data_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam sapq_pkg::data_t VAL_MIN = 32'sh8000_0000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = sapq_pkg::DEPTH + 8;
    localparam int MAX_REPORTS = 10;

    // Tracks queue contents and the results each request should produce.
    class queue_scoreboard;
        sapq_pkg::data_t     held[sapq_pkg::DEPTH];
        int                  held_cnt = 0;
        sapq_pkg::out_item_t expected_q[$];
        int                  errors = 0;
        int                  checked = 0;
        int                  status_seen[4] = '{default: 0};
        int                  req_seen[4] = '{default: 0};

        function void push_result(logic [1:0] sts, sapq_pkg::data_t val, logic lst);
            sapq_pkg::out_item_t r;
            r.status = sts;
            r.entry_value = val;
            r.entry_count = sapq_pkg::CNT_W'(held_cnt);
            r.last = lst;
            expected_q.push_back(r);
            status_seen[sts]++;
        endfunction

        function void note_request(sapq_pkg::in_item_t req);
            sapq_pkg::data_t v;
            int              pos;
            int              k;
            v = req.value;
            req_seen[req.req_type]++;
            case (req.req_type)
                sapq_pkg::REQ_INSERT:
                begin
                    if (held_cnt >= sapq_pkg::DEPTH)
                    begin
                        push_result(sapq_pkg::STS_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        // new value goes ahead of older equal ones
                        pos = 0;
                        while (pos < held_cnt && v < held[pos])
                            pos++;
                        for (k = held_cnt; k > pos; k--)
                            held[k] = held[k-1];
                        held[pos] = v;
                        held_cnt++;
                        push_result(sapq_pkg::STS_OK, '0, 1'b1);
                    end
                end
                sapq_pkg::REQ_DELETE:
                begin
                    if (held_cnt == 0)
                    begin
                        push_result(sapq_pkg::STS_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < held_cnt && held[pos] != v)
                            pos++;
                        if (pos == held_cnt)
                        begin
                            push_result(sapq_pkg::STS_NOTFOUND, '0, 1'b1);
                        end
                        else
                        begin
                            for (k = pos; k + 1 < held_cnt; k++)
                                held[k] = held[k+1];
                            held_cnt--;
                            push_result(sapq_pkg::STS_OK, '0, 1'b1);
                        end
                    end
                end
                sapq_pkg::REQ_READ:
                begin
                    if (held_cnt == 0)
                        push_result(sapq_pkg::STS_EMPTY, '0, 1'b1);
                    else
                        for (k = 0; k < held_cnt; k++)
                            push_result(sapq_pkg::STS_OK, held[k], k == held_cnt - 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(sapq_pkg::out_item_t got);
            sapq_pkg::out_item_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result status %0d value %0d count %0d last %0b",
                             got.status, got.entry_value, got.entry_count, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.entry_value !== want.entry_value ||
                got.entry_count !== want.entry_count || got.last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %0d expected sts %0d val %0d cnt %0d last %0b, %s",
                             checked, want.status, want.entry_value, want.entry_count,
                             want.last, $sformatf("got sts %0d val %0d cnt %0d last %0b",
                             got.status, got.entry_value, got.entry_count, got.last));
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sapq_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    sapq_pkg::out_item_t out_data;

    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        filling = 1'b1;

    queue_scoreboard sb = new();

    sorted_array_priority_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    task automatic send_request(input sapq_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(it);
    endtask

    task automatic send_op(input logic [1:0] req, input sapq_pkg::data_t val);
        sapq_pkg::in_item_t it;
        it.req_type = req;
        it.value = val;
        send_request(it);
    endtask

    // hold off new requests until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    function automatic sapq_pkg::data_t random_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return sapq_pkg::data_t'($urandom_range(8)) - 4;
            4:
            begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return sapq_pkg::data_t'($urandom);
        endcase
    endfunction

    // fill and drain in turns so the count sweeps from empty to full and back
    task automatic pick_request(output sapq_pkg::in_item_t it);
        int roll;
        if (sb.held_cnt == 0)
            filling = 1'b1;
        else if (sb.held_cnt == sapq_pkg::DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
        roll = $urandom_range(99);
        it.value = random_value();
        if (roll < 4)
            it.req_type = REQ_UNUSED;
        else if (roll < 22)
            it.req_type = sapq_pkg::REQ_READ;
        else if (roll < (filling ? 72 : 40))
            it.req_type = sapq_pkg::REQ_INSERT;
        else
        begin
            it.req_type = sapq_pkg::REQ_DELETE;
            if (sb.held_cnt > 0 && $urandom_range(99) < 75)
                it.value = sb.held[$urandom_range(sb.held_cnt - 1)];
        end
    endtask

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("ERROR: timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int                 k;
        int                 phase;
        int                 n;
        int                 leftover;
        sapq_pkg::in_item_t it;
        int                 idle_plan[3];
        int                 stall_plan[3];
        int                 items_plan[3];
        idle_plan = '{23, 49, 0};
        stall_plan = '{49, 23, 0};
        items_plan = '{145, 145, 145};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = idle_plan[0];
        recv_stall_pct = stall_plan[0];

        // empty cases and the unused code, then extreme values, a tie and deletes
        send_op(sapq_pkg::REQ_READ, '0);
        send_op(sapq_pkg::REQ_DELETE, 32'sd3);
        send_op(REQ_UNUSED, 32'sh1234_5678);
        send_op(sapq_pkg::REQ_INSERT, VAL_MAX);
        send_op(sapq_pkg::REQ_INSERT, VAL_MIN);
        send_op(sapq_pkg::REQ_INSERT, '0);
        send_op(sapq_pkg::REQ_INSERT, '1);
        send_op(sapq_pkg::REQ_INSERT, 32'sd5);
        send_op(sapq_pkg::REQ_INSERT, 32'sd5);
        send_op(sapq_pkg::REQ_DELETE, 32'sd7);
        send_op(sapq_pkg::REQ_DELETE, 32'sd5);
        send_op(sapq_pkg::REQ_READ, '0);
        // fill up, with ties at both ends, then one insert too many and a read
        for (k = 0; k < 11; k++)
            send_op(sapq_pkg::REQ_INSERT,
                    k == 0 ? VAL_MAX : k == 1 ? VAL_MIN : sapq_pkg::data_t'($urandom));
        send_op(sapq_pkg::REQ_INSERT, 32'sd42);
        send_op(sapq_pkg::REQ_READ, '0);
        drain_results();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = idle_plan[phase];
            recv_stall_pct = stall_plan[phase];
            n = 0;
            while (n < items_plan[phase])
            begin
                pick_request(it);
                send_request(it);
                n++;
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        leftover = sb.expected_q.size();
        if (leftover != 0)
            $display("ERROR: %0d expected results never arrived", leftover);

        $display("Covered %0d inserts, %0d deletes, %0d reads, %0d ignored; %0d results checked",
                 sb.req_seen[sapq_pkg::REQ_INSERT], sb.req_seen[sapq_pkg::REQ_DELETE],
                 sb.req_seen[sapq_pkg::REQ_READ], sb.req_seen[REQ_UNUSED], sb.checked);
        $display("Status hits: ok %0d, full %0d, empty %0d, not found %0d; mismatches %0d",
                 sb.status_seen[sapq_pkg::STS_OK], sb.status_seen[sapq_pkg::STS_FULL],
                 sb.status_seen[sapq_pkg::STS_EMPTY], sb.status_seen[sapq_pkg::STS_NOTFOUND],
                 sb.errors);
        if (sb.errors == 0 && leftover == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
